@@ rtl/sfr_pkg.sv @@
// Package for the streaming find-and-replace block.
// Holds configuration codes, shared structs and byte-mask helpers; depends on nothing.
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int MAX_PATTERN_BYTES = 8;
	localparam int REPL_MAX_BYTES    = 8;
	localparam int WIN_BYTES         = 8;
	localparam int WIN_W             = 8 * WIN_BYTES;
	localparam int LEN_W             = 4;
	localparam int CNT_W             = 3;

	typedef enum logic [1:0] {
		CFG_PATTERN_BYTES,
		CFG_PATTERN_LENGTH,
		CFG_REPLACEMENT_BYTES,
		CFG_REPLACEMENT_LENGTH
	} cfg_index_t;

	// Effective configuration as seen by the matcher.
	typedef struct packed {
		logic [WIN_W-1:0] pat;
		logic [LEN_W-1:0] plen;
		logic [WIN_W-1:0] rep;
		logic [LEN_W-1:0] rlen;
	} cfg_t;

	// A group of up to eight results caused by one input transaction.
	typedef struct packed {
		logic [WIN_W-1:0] bytes;
		logic [LEN_W-1:0] count;
		logic             eos;
		logic             empty;
	} burst_t;

	function automatic logic [WIN_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
		logic [WIN_W-1:0] m;
		m = '0;
		for (int i = 0; i < WIN_BYTES; i++) begin
			m[8*i +: 8] = (LEN_W'(i) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	function automatic logic [LEN_W-1:0] cap_len(input logic [LEN_W-1:0] len,
		input logic [LEN_W-1:0] cap);
		return (len > cap) ? cap : len;
	endfunction

endpackage

@@ rtl/sfr_step.sv @@
// Pattern window and the per-byte match step of the find-and-replace block.
// Depends on sfr_pkg for the configuration and burst structs.
`timescale 1ns / 1ps

module sfr_step import sfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             clear,
	input  logic             step_en,
	input  logic [7:0]       data_byte,
	input  logic             end_of_stream,
	output burst_t           burst,
	output logic [CNT_W-1:0] win_count
);

	logic [WIN_W-1:0] window_q;
	logic [CNT_W-1:0] count_q;
	logic [WIN_W-1:0] win_ins;
	logic [WIN_W-1:0] pmask;
	logic [LEN_W-1:0] cnt1;
	logic             full;
	logic             hit;
	logic [WIN_W-1:0] next_win;
	logic [CNT_W-1:0] next_cnt;

	always_comb begin
		win_ins = (window_q & byte_mask({1'b0, count_q}))
			| ({{(WIN_W-8){1'b0}}, data_byte} << {count_q, 3'b000});
		cnt1    = {1'b0, count_q} + LEN_W'(1);
		full    = cnt1 >= cfg.plen;
		pmask   = byte_mask(cfg.plen);
		hit     = full && ((win_ins & pmask) == (cfg.pat & pmask));

		burst    = '0;
		next_win = window_q;
		next_cnt = count_q;

		if (cfg.plen == '0) begin
			// Pass-through: every byte goes straight out.
			burst.bytes = {{(WIN_W-8){1'b0}}, data_byte};
			burst.count = LEN_W'(1);
			next_win    = '0;
			next_cnt    = '0;
		end else if (hit) begin
			burst.bytes = cfg.rep;
			burst.count = cfg.rlen;
			next_win    = '0;
			next_cnt    = '0;
		end else if (full) begin
			// Oldest byte leaves; on the last byte the rest follows it.
			burst.bytes = win_ins;
			burst.count = end_of_stream ? cfg.plen : LEN_W'(1);
			next_win    = win_ins >> 8;
			next_cnt    = CNT_W'(cfg.plen - LEN_W'(1));
		end else begin
			burst.bytes = win_ins;
			burst.count = end_of_stream ? cnt1 : '0;
			next_win    = win_ins;
			next_cnt    = cnt1[CNT_W-1:0];
		end

		if (end_of_stream) begin
			next_win = '0;
			next_cnt = '0;
			if (burst.count == '0) begin
				burst.bytes = '0;
				burst.count = LEN_W'(1);
				burst.empty = 1'b1;
			end
		end
		burst.eos = end_of_stream;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			count_q  <= '0;
		end else if (clear) begin
			window_q <= '0;
			count_q  <= '0;
		end else if (step_en) begin
			window_q <= next_win;
			count_q  <= next_cnt;
		end
	end

	assign win_count = count_q;

endmodule

@@ rtl/sfr_burst.sv @@
// Result register that serializes one burst of results, one per output transaction.
// Depends on sfr_pkg for the burst struct.
`timescale 1ns / 1ps

module sfr_burst import sfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  burst_t     burst_in,
	output logic       load_ready,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_present,
	output logic       run_last,
	output logic       stream_last
);

	logic             valid_q;
	logic [WIN_W-1:0] bytes_q;
	logic [LEN_W-1:0] count_q;
	logic             eos_q;
	logic             empty_q;
	logic             take;

	assign run_last     = count_q == LEN_W'(1);
	assign stream_last  = run_last && eos_q;
	assign out_byte     = bytes_q[7:0];
	assign byte_present = !empty_q;
	assign out_valid    = valid_q;
	assign take         = valid_q && !out_stall;
	assign load_ready   = !valid_q || (take && run_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			count_q <= burst_in.count;
		end else if (take) begin
			valid_q <= !run_last;
			count_q <= count_q - LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst_in.bytes;
			eos_q   <= burst_in.eos;
			empty_q <= burst_in.empty;
		end else if (take) begin
			bytes_q <= bytes_q >> 8;
		end
	end

endmodule

@@ rtl/stream_find_replace_top.sv @@
// Top level of the streaming find-and-replace block.
// Depends on sfr_pkg, sfr_step and sfr_burst.
`timescale 1ns / 1ps

// Streaming find-and-replace: bytes come in one per input transaction and every leftmost,
// non-overlapping occurrence of the configured pattern (up to eight bytes) is replaced by
// the configured replacement (up to eight bytes, zero deletes the match). A byte that can
// no longer start a match leaves as soon as the window fills to the pattern length, and
// the byte marked end_of_stream flushes everything still pending; if that byte produces
// no data, a single result with byte_present low closes the stream. A pattern length of
// zero passes bytes through unchanged. The block accepts one byte per cycle while each
// byte causes at most one result and the output does not stall; a byte that causes more
// results (a replacement or a flush) holds the output result register until all are
// taken, and the input stalls while the next byte's results wait for it. A byte passes
// through an input register and the output result register. The user writes configuration
// through cfg_we, cfg_index and cfg_data only while no transaction is in flight; the block
// does not enforce this. Writing the pattern length discards any pending bytes.
module stream_find_replace_top import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_present,
	output logic        run_last,
	output logic        stream_last
);

	logic [WIN_W-1:0] pat_q;
	logic [LEN_W-1:0] plen_q;
	logic [WIN_W-1:0] rep_q;
	logic [LEN_W-1:0] rlen_q;
	cfg_t             cfg;
	cfg_index_t       widx;
	logic             clear_win;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eos_s1;

	burst_t           burst;
	logic             load_ready;
	logic             step_fire;
	logic             load;
	logic [CNT_W-1:0] win_count;

	// Configuration registers. Lengths above their limits are clamped on use.
	assign widx      = cfg_index_t'(cfg_index);
	assign clear_win = cfg_we && (widx == CFG_PATTERN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			plen_q <= '0;
			rep_q  <= '0;
			rlen_q <= '0;
		end else if (cfg_we) begin
			unique case (widx)
				CFG_PATTERN_BYTES:      pat_q  <= cfg_data;
				CFG_PATTERN_LENGTH:     plen_q <= cfg_data[LEN_W-1:0];
				CFG_REPLACEMENT_BYTES:  rep_q  <= cfg_data;
				CFG_REPLACEMENT_LENGTH: rlen_q <= cfg_data[LEN_W-1:0];
				default:                pat_q  <= pat_q;
			endcase
		end
	end

	assign cfg.pat  = pat_q;
	assign cfg.plen = cap_len(plen_q, LEN_W'(MAX_PATTERN_BYTES));
	assign cfg.rep  = rep_q;
	assign cfg.rlen = cap_len(rlen_q, LEN_W'(REPL_MAX_BYTES));

	// The held byte moves on when its results fit into the result register, or at once
	// when it causes no result at all.
	assign step_fire = valid_s1 && ((burst.count == '0) || load_ready);
	assign load      = step_fire && (burst.count != '0);
	assign in_stall  = valid_s1 && !step_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			eos_s1  <= end_of_stream;
		end
	end

	sfr_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.clear         (clear_win),
		.step_en       (step_fire),
		.data_byte     (byte_s1),
		.end_of_stream (eos_s1),
		.burst         (burst),
		.win_count     (win_count)
	);

	sfr_burst u_burst (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.burst_in     (burst),
		.load_ready   (load_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.run_last     (run_last),
		.stream_last  (stream_last)
	);

	// The window never holds a whole pattern's worth of bytes between steps.
	a_win_below_plen: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.plen != '0) |-> ({1'b0, win_count} < cfg.plen))
		else $error("pending window reached the pattern length");

	// In pass-through mode nothing is ever pending.
	a_win_empty_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.plen == '0) |-> (win_count == '0))
		else $error("bytes pending while pattern length is zero");

	// The empty marker only ever closes a stream.
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_present) |-> (run_last && stream_last))
		else $error("empty result that does not close the stream");

	// A byte that is held back is always waiting on the result register.
	a_stall_waits_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && burst.count != '0))
		else $error("input stalled while results could be taken");

endmodule

@@ test/stream_find_replace_top_test.sv @@
// Self-checking testbench for the streaming find-and-replace block.
// Drives byte transactions with random gaps and stalls, predicts the rewritten stream
// and compares every result; depends on sfr_pkg and stream_find_replace_top.
`timescale 1ns / 1ps

module stream_find_replace_top_test;
	import sfr_pkg::*;

	localparam int          RUN_LIMIT_NS = 3_000_000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned LONG_HOLD    = 200;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned PHASE_ITEMS  = 18;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] value;
		logic       present;
		logic       run_end;
		logic       stream_end;
	} rewritten_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	cfg_index_t  cfg_index     = CFG_PATTERN_BYTES;
	logic [63:0] cfg_data      = '0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte     = '0;
	logic        end_of_stream = 1'b0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_present;
	logic        run_last;
	logic        stream_last;

	stream_find_replace_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.run_last     (run_last),
		.stream_last  (stream_last)
	);

	// Bytes waiting to be offered, and the rewritten results still owed by the block.
	byte_item_t  text_q[$];
	rewritten_t  rewritten_q[$];
	int unsigned queued_total   = 0;
	int unsigned accepted_total = 0;
	int unsigned mismatch_count = 0;

	// Handshake bookkeeping: what was taken at the last rising edge.
	logic        in_taken  = 1'b0;
	logic        out_taken = 1'b0;
	int unsigned tx_gap_max    = 12;
	int unsigned rx_gap_max    = 12;
	int unsigned tx_gap_left   = 0;
	int unsigned rx_wait_left  = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_served  = 0;

	// Predictor copy of the configuration and the pending window.
	logic [63:0] pat_cfg   = '0;
	logic [3:0]  plen_cfg  = '0;
	logic [63:0] rep_cfg   = '0;
	logic [3:0]  rlen_cfg  = '0;
	logic [63:0] win_bytes = '0;
	logic [3:0]  win_count = '0;

	logic [7:0]  alphabet [4];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

	function automatic int unsigned draw_gap(input int unsigned max_gap);
		if (max_gap == 0 || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, max_gap);
	endfunction

	function automatic logic [63:0] low_bytes_mask(input int unsigned n);
		if (n >= 8)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic rewritten_t make_result(input logic [7:0] value, input logic present);
		rewritten_t r;
		r.value      = value;
		r.present    = present;
		r.run_end    = 1'b0;
		r.stream_end = 1'b0;
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	// Works out the results that one accepted byte causes and queues them.
	task automatic rewrite_byte(input logic [7:0] b, input logic last);
		rewritten_t  outs[$];
		int unsigned plen;
		int unsigned rlen;
		int unsigned cnt;
		int unsigned i;
		logic [63:0] m;
		plen = (plen_cfg > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : plen_cfg;
		rlen = (rlen_cfg > REPL_MAX_BYTES) ? REPL_MAX_BYTES : rlen_cfg;
		if (plen == 0) begin
			outs.push_back(make_result(b, 1'b1));
		end else begin
			cnt = win_count & 4'd7;
			win_bytes = (win_bytes & low_bytes_mask(cnt)) | (64'(b) << (8 * cnt));
			cnt++;
			if (cnt >= plen) begin
				m = low_bytes_mask(plen);
				if ((win_bytes & m) == (pat_cfg & m)) begin
					for (i = 0; i < rlen; i++)
						outs.push_back(make_result(rep_cfg[8*i +: 8], 1'b1));
					win_bytes = '0;
					cnt = 0;
				end else begin
					outs.push_back(make_result(win_bytes[7:0], 1'b1));
					win_bytes = win_bytes >> 8;
					cnt--;
				end
			end
			if (last) begin
				for (i = 0; i < cnt; i++)
					outs.push_back(make_result(win_bytes[8*i +: 8], 1'b1));
				win_bytes = '0;
				cnt = 0;
			end
			win_count = cnt[3:0];
		end
		// The end of a stream always yields something, if only an empty marker.
		if (last && outs.size() == 0)
			outs.push_back(make_result(8'h00, 1'b0));
		if (outs.size() != 0) begin
			outs[outs.size()-1].run_end    = 1'b1;
			outs[outs.size()-1].stream_end = last;
		end
		foreach (outs[k])
			rewritten_q.push_back(outs[k]);
	endtask

	// Register write while the block is idle; the predictor follows immediately.
	task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			CFG_PATTERN_BYTES:      pat_cfg = value;
			CFG_PATTERN_LENGTH: begin
				plen_cfg  = value[3:0];
				win_bytes = '0;
				win_count = '0;
			end
			CFG_REPLACEMENT_BYTES:  rep_cfg = value;
			CFG_REPLACEMENT_LENGTH: rlen_cfg = value[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Phase settings are changed at a rising edge so the negedge processes see them cleanly.
	task automatic start_phase(input int unsigned tx_max, input int unsigned rx_max,
		input logic long_hold);
		@(posedge clk);
		tx_gap_max = tx_max;
		rx_gap_max = rx_max;
		if (long_hold)
			hold_requests++;
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic last);
		byte_item_t item;
		item.data = b;
		item.last = last;
		text_q.push_back(item);
		queued_total++;
	endtask

	// Waits until every queued byte was taken and every predicted result arrived,
	// then lets the block's latency run out.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (accepted_total != queued_total || rewritten_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly whole patterns, some spoiled by one flipped bit, prefixes and noise.
	task automatic queue_random_stream(input int unsigned n_items);
		logic [7:0]  text[$];
		int unsigned plen;
		int unsigned pick;
		int unsigned cut;
		int unsigned k;
		logic [7:0]  b;
		plen = (plen_cfg > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : plen_cfg;
		while (text.size() < n_items) begin
			pick = $urandom_range(0, 9);
			if (plen != 0 && pick < 6) begin
				cut = $urandom_range(0, plen - 1);
				for (k = 0; k < plen; k++) begin
					b = pat_cfg[8*k +: 8];
					if (pick == 5 && k == cut)
						b = b ^ (8'd1 << $urandom_range(0, 7));
					text.push_back(b);
				end
			end else if (plen > 1 && pick < 8) begin
				cut = $urandom_range(1, plen - 1);
				for (k = 0; k < cut; k++)
					text.push_back(pat_cfg[8*k +: 8]);
			end else if (pick == 8) begin
				text.push_back(8'($urandom));
			end else begin
				text.push_back(alphabet[$urandom_range(0, 3)]);
			end
		end
		for (k = 0; k < text.size(); k++)
			queue_byte(text[k], (k == text.size() - 1) || ($urandom_range(0, 11) == 0));
	endtask

	// Sender: holds a payload until it is taken, then waits its drawn gap.
	always @(negedge clk) begin : feed_bytes
		byte_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// Still waiting for the transaction to be accepted.
		end else if (tx_gap_left != 0) begin
			in_valid    <= 1'b0;
			tx_gap_left <= tx_gap_left - 1;
		end else if (text_q.size() != 0) begin
			item = text_q.pop_front();
			data_byte     <= item.data;
			end_of_stream <= item.last;
			in_valid      <= 1'b1;
			tx_gap_left   <= draw_gap(tx_gap_max);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: stalls for a drawn number of cycles after each result, and once in a
	// while for a long stretch so the block backs up into its input.
	always @(negedge clk) begin : drain_results
		int unsigned w;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_requests != holds_served) begin
			holds_served <= holds_served + 1;
			out_stall    <= 1'b1;
			rx_wait_left <= LONG_HOLD - 1;
		end else if (rx_wait_left != 0) begin
			out_stall    <= 1'b1;
			rx_wait_left <= rx_wait_left - 1;
		end else if (out_taken) begin
			w = draw_gap(rx_gap_max);
			out_stall    <= (w != 0);
			rx_wait_left <= (w != 0) ? w - 1 : 0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: checks accepted results against the oldest prediction, and predicts
	// for every accepted byte.
	always @(posedge clk) begin : watch_ports
		rewritten_t want;
		if (!arst_n) begin
			in_taken  <= 1'b0;
			out_taken <= 1'b0;
		end else begin
			in_taken  <= in_valid && !in_stall;
			out_taken <= out_valid && !out_stall;
			if (out_valid && !out_stall) begin
				if (rewritten_q.size() == 0) begin
					flag_mismatch($sformatf("result %02h with nothing predicted", out_byte));
				end else begin
					want = rewritten_q.pop_front();
					if (out_byte !== want.value)
						flag_mismatch($sformatf("out_byte %02h, predicted %02h",
							out_byte, want.value));
					if (byte_present !== want.present)
						flag_mismatch($sformatf("byte_present %b, predicted %b",
							byte_present, want.present));
					if (run_last !== want.run_end)
						flag_mismatch($sformatf("run_last %b, predicted %b",
							run_last, want.run_end));
					if (stream_last !== want.stream_end)
						flag_mismatch($sformatf("stream_last %b, predicted %b",
							stream_last, want.stream_end));
				end
			end
			if (in_valid && !in_stall) begin
				accepted_total++;
				rewrite_byte(data_byte, end_of_stream);
			end
		end
	end

	initial begin : run_phases
		int unsigned p;
		int unsigned i;
		int unsigned plen_tab [PHASES];
		int unsigned rlen_tab [PHASES];
		logic [63:0] pat;
		plen_tab = '{1, 8, 0, 15, 2, 3, 5, 4};
		rlen_tab = '{8, 0, 1, 12, 3, 2, 15, 5};

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Two-byte pattern replaced by three bytes, with overlapping near-matches.
		write_reg(CFG_PATTERN_BYTES, 64'h6261);
		write_reg(CFG_PATTERN_LENGTH, 64'd2);
		write_reg(CFG_REPLACEMENT_BYTES, 64'h5a5958);
		write_reg(CFG_REPLACEMENT_LENGTH, 64'd3);
		start_phase(12, 12, 1'b0);
		queue_byte("a", 1'b0);
		queue_byte("b", 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte("a", 1'b0);
		queue_byte("a", 1'b0);
		queue_byte("b", 1'b0);
		queue_byte("c", 1'b1);
		wait_idle();

		// Zero pattern length: bytes pass straight through.
		write_reg(CFG_PATTERN_LENGTH, 64'd0);
		start_phase(12, 12, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		wait_idle();

		// Zero bytes as pattern, deleted matches, and an end that emits nothing.
		write_reg(CFG_PATTERN_BYTES, 64'd0);
		write_reg(CFG_PATTERN_LENGTH, 64'd3);
		write_reg(CFG_REPLACEMENT_LENGTH, 64'd0);
		start_phase(12, 12, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b1);
		wait_idle();

		// Oversized lengths fall back to eight bytes on both sides.
		write_reg(CFG_PATTERN_BYTES, 64'hFEDCBA9876543210);
		write_reg(CFG_PATTERN_LENGTH, 64'd15);
		write_reg(CFG_REPLACEMENT_BYTES, 64'h0123456789ABCDEF);
		write_reg(CFG_REPLACEMENT_LENGTH, 64'd12);
		start_phase(12, 12, 1'b0);
		for (i = 0; i < 8; i++)
			queue_byte(pat_cfg[8*i +: 8], i == 7);
		wait_idle();

		// Rewriting the pattern length mid-stream throws away the pending prefix.
		write_reg(CFG_PATTERN_BYTES, 64'h44332211);
		write_reg(CFG_PATTERN_LENGTH, 64'd4);
		start_phase(12, 12, 1'b0);
		queue_byte(8'h11, 1'b0);
		queue_byte(8'h22, 1'b0);
		wait_idle();
		write_reg(CFG_PATTERN_LENGTH, 64'd4);
		start_phase(12, 12, 1'b0);
		queue_byte(8'h33, 1'b1);
		wait_idle();

		// Random phases. Phase 3 has long bursts and a long receiver hold-off while the
		// sender keeps offering; phase 5 runs with no idling at all.
		for (p = 0; p < PHASES; p++) begin
			alphabet[0] = 8'h00;
			alphabet[1] = 8'hFF;
			alphabet[2] = 8'($urandom);
			alphabet[3] = 8'($urandom);
			for (i = 0; i < 8; i++)
				pat[8*i +: 8] = (i < plen_tab[p]) ? alphabet[$urandom_range(0, 3)]
					: 8'($urandom);
			write_reg(CFG_PATTERN_BYTES, pat);
			write_reg(CFG_PATTERN_LENGTH, 64'(p == PHASES - 1 ? $urandom_range(0, 9)
				: plen_tab[p]));
			write_reg(CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
			write_reg(CFG_REPLACEMENT_LENGTH, 64'(p == PHASES - 1 ? $urandom_range(0, 15)
				: rlen_tab[p]));
			if (p == 3)
				start_phase(0, 12, 1'b1);
			else if (p == 5)
				start_phase(0, 0, 1'b0);
			else
				start_phase(12, 12, 1'b0);
			queue_random_stream(PHASE_ITEMS);
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
